/* src/egcd_pkg.sv */
// Shared types and constants for the extended Euclid GCD core.
package egcd_pkg;

  // Sequencer states, one-hot coded.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETUP  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } egcd_state_e;

endpackage

/* src/egcd_if.sv */
// Valid/ready stream interfaces for the operand and result channels.
interface egcd_in_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value_a;
  logic signed [WIDTH-1:0] value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface egcd_out_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic        [WIDTH-2:0] divisor;
  logic signed [WIDTH-1:0] coef_a;
  logic signed [WIDTH-1:0] coef_b;

  modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
  modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);
endinterface

/* src/extended_euclid_gcd_core.sv */
// Extended Euclid GCD core: one shared divide step under a small sequencer.
//
//  Channel  Direction  Signals                          Item
//  in_i     sink       valid, ready, value_a, value_b   one operand pair
//  out_o    source     valid, ready, divisor, coef_*    gcd and Bezout coefficients
//
// A result is registered once its item has gone through setup and finish when an operand is zero
// or both magnitudes are equal, and through k Euclid steps otherwise, where k is at most 44
// for WIDTH = 32; each step runs a restoring divider one quotient bit per cycle, then an
// update state.
// Reset clears the sequencer and the output valid; the datapath needs no reset.
// The input is ready only while idle; a full output register holds the finish state.
module extended_euclid_gcd_core #(
  parameter int WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  egcd_in_if.sink       in_i,
  egcd_out_if.source    out_o
);
  import egcd_pkg::*;

  localparam int MW = WIDTH - 1;
  localparam int CW = $clog2(MW);

  egcd_state_e state_q, state_d;

  logic [MW-1:0]    mag_a_q, mag_b_q;
  logic [MW-1:0]    rem_q, quo_q, div_q;
  logic [WIDTH-1:0] p_q, q_q, r_q, s_q;
  logic [WIDTH-1:0] mr_q, ms_q;
  logic [CW-1:0]    cnt_q;
  logic             swap_q;

  logic             out_valid_q;
  logic [MW-1:0]    out_div_q;
  logic [WIDTH-1:0] out_ca_q, out_cb_q;

  logic [MW:0]      rem_ext;
  logic [MW:0]      trial;
  logic             qbit;
  logic             in_acc;
  logic             out_free;

  // Magnitude of a two's complement value; the most negative value saturates.
  function automatic logic [MW-1:0] abs_sat(input logic [WIDTH-1:0] v);
    logic [WIDTH-1:0] n;
    n = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    return n[WIDTH-1] ? {MW{1'b1}} : n[MW-1:0];
  endfunction

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Shared divide step: shift in one dividend bit and try the subtraction.
  assign rem_ext = {rem_q, quo_q[MW-1]};
  assign trial   = rem_ext - {1'b0, div_q};
  assign qbit    = !trial[MW];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (mag_b_q == '0 || mag_a_q == '0 || mag_a_q == mag_b_q) state_d = ST_FINISH;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (rem_q == '0) state_d = ST_FINISH;
        else state_d = ST_DIV;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: operand capture, divide steps and coefficient updates.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mag_a_q <= abs_sat(in_i.value_a);
          mag_b_q <= abs_sat(in_i.value_b);
        end
      end
      ST_SETUP: begin
        if (mag_b_q == '0 || mag_a_q == mag_b_q) begin
          div_q  <= mag_a_q;
          p_q    <= WIDTH'(1);
          q_q    <= '0;
          swap_q <= 1'b0;
        end else if (mag_a_q == '0) begin
          div_q  <= mag_b_q;
          p_q    <= '0;
          q_q    <= WIDTH'(1);
          swap_q <= 1'b0;
        end else begin
          // Smaller magnitude first; its trivial first step is skipped.
          swap_q <= mag_a_q > mag_b_q;
          quo_q  <= (mag_a_q > mag_b_q) ? mag_a_q : mag_b_q;
          div_q  <= (mag_a_q > mag_b_q) ? mag_b_q : mag_a_q;
          rem_q  <= '0;
          mr_q   <= '0;
          ms_q   <= '0;
          cnt_q  <= CW'(MW - 1);
          p_q    <= '0;
          q_q    <= WIDTH'(1);
          r_q    <= WIDTH'(1);
          s_q    <= '0;
        end
      end
      ST_DIV: begin
        // Quotient bits arrive MSB first, so quo*r and quo*s build up by Horner.
        rem_q <= qbit ? trial[MW-1:0] : rem_ext[MW-1:0];
        quo_q <= {quo_q[MW-2:0], qbit};
        mr_q  <= {mr_q[WIDTH-2:0], 1'b0} + (qbit ? r_q : '0);
        ms_q  <= {ms_q[WIDTH-2:0], 1'b0} + (qbit ? s_q : '0);
        cnt_q <= cnt_q - CW'(1);
      end
      ST_UPDATE: begin
        p_q <= r_q;
        q_q <= s_q;
        r_q <= p_q - mr_q;
        s_q <= q_q - ms_q;
        if (rem_q != '0) begin
          // Next step divides the old divisor by the remainder.
          quo_q <= div_q;
          div_q <= rem_q;
          rem_q <= '0;
          mr_q  <= '0;
          ms_q  <= '0;
          cnt_q <= CW'(MW - 1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; coefficients go back to the original operand order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_div_q <= div_q;
      out_ca_q  <= swap_q ? q_q : p_q;
      out_cb_q  <= swap_q ? p_q : q_q;
    end
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.divisor = out_div_q;
  assign out_o.coef_a  = out_ca_q;
  assign out_o.coef_b  = out_cb_q;

  // The sequencer always holds exactly one state.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != '0)
    else $error("divide step with zero divisor");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < div_q)
    else $error("partial remainder not below divisor");

  // A new result only comes from the finish state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside finish state");

  // A nonzero remainder always starts a fresh division.
  a_next_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && rem_q != '0) |=> (state_q == ST_DIV && cnt_q == CW'(MW - 1)))
    else $error("next division not started");

endmodule

/* sim/extended_euclid_gcd_core_test.sv */
// Self-checking testbench for the extended Euclid GCD core.

localparam int GCD_W = 32;

typedef logic [GCD_W-1:0] word_t;

// One expected result, kept with the operands that caused it.
typedef struct packed {
  word_t              value_a;
  word_t              value_b;
  logic [GCD_W-2:0]   divisor;
  word_t              coef_a;
  word_t              coef_b;
} bezout_t;

// Predicts gcd and Bezout coefficients and holds them until the results arrive.
class bezout_tracker;
  bezout_t pending_results[$];
  int      mismatch_count;

  function new();
    mismatch_count = 0;
  endfunction

  // Magnitude of a two's complement word; the most negative value saturates.
  function word_t clamp_magnitude(word_t raw);
    word_t mag;
    mag = raw[GCD_W-1] ? (~raw + 1'b1) : raw;
    if (mag > {1'b0, {(GCD_W-1){1'b1}}}) begin
      mag = {1'b0, {(GCD_W-1){1'b1}}};
    end
    return mag;
  endfunction

  // Iterative extended Euclid on lo < hi, with wrapping word arithmetic.
  function void run_euclid(input word_t lo, input word_t hi,
                           output word_t g, output word_t c_lo, output word_t c_hi);
    word_t x, y, p, q, r, s, quo, rem, nr, ns;
    x = lo;
    y = hi;
    p = 1;
    q = 0;
    r = 0;
    s = 1;
    while (y != 0) begin
      quo = x / y;
      rem = x % y;
      nr  = p - quo * r;
      ns  = q - quo * s;
      x   = y;
      y   = rem;
      p   = r;
      q   = s;
      r   = nr;
      s   = ns;
    end
    g    = x;
    c_lo = p;
    c_hi = q;
  endfunction

  function bezout_t predict_bezout(word_t value_a, word_t value_b);
    bezout_t res;
    word_t   mag_a, mag_b, g, ca, cb;
    mag_a = clamp_magnitude(value_a);
    mag_b = clamp_magnitude(value_b);
    // Zero operands and exact divisibility are answered without iterating.
    if (mag_b == 0) begin
      g = mag_a; ca = 1; cb = 0;
    end else if (mag_a == 0) begin
      g = mag_b; ca = 0; cb = 1;
    end else if (mag_b % mag_a == 0) begin
      g = mag_a; ca = 1; cb = 0;
    end else if (mag_a % mag_b == 0) begin
      g = mag_b; ca = 0; cb = 1;
    end else if (mag_a > mag_b) begin
      run_euclid(mag_b, mag_a, g, cb, ca);
    end else begin
      run_euclid(mag_a, mag_b, g, ca, cb);
    end
    res.value_a = value_a;
    res.value_b = value_b;
    res.divisor = g[GCD_W-2:0];
    res.coef_a  = ca;
    res.coef_b  = cb;
    return res;
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called for every operand pair the core accepts.
  function void note_pair(word_t value_a, word_t value_b);
    pending_results.push_back(predict_bezout(value_a, value_b));
  endfunction

  // Called for every result the core hands over.
  task check_result(logic [GCD_W-2:0] divisor, word_t coef_a, word_t coef_b);
    bezout_t exp_res;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result divisor=%0d coef_a=%0d coef_b=%0d",
                                divisor, $signed(coef_a), $signed(coef_b)));
    end else begin
      exp_res = pending_results.pop_front();
      if (divisor !== exp_res.divisor) begin
        report_mismatch($sformatf("a=%0d b=%0d divisor got %0d exp %0d",
                                  $signed(exp_res.value_a), $signed(exp_res.value_b),
                                  divisor, exp_res.divisor));
      end
      if (coef_a !== exp_res.coef_a) begin
        report_mismatch($sformatf("a=%0d b=%0d coef_a got %0d exp %0d",
                                  $signed(exp_res.value_a), $signed(exp_res.value_b),
                                  $signed(coef_a), $signed(exp_res.coef_a)));
      end
      if (coef_b !== exp_res.coef_b) begin
        report_mismatch($sformatf("a=%0d b=%0d coef_b got %0d exp %0d",
                                  $signed(exp_res.value_a), $signed(exp_res.value_b),
                                  $signed(coef_b), $signed(exp_res.coef_b)));
      end
    end
  endtask
endclass

module extended_euclid_gcd_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t MAX_POS  = 32'h7FFF_FFFF;
  localparam word_t MOST_NEG = 32'h8000_0000;
  localparam word_t FIB_46   = 32'd1836311903;
  localparam word_t FIB_45   = 32'd1134903170;
  localparam int    NUM_RANDOM = 390;

  logic clk_i;
  logic rst_ni;

  egcd_in_if  #(.WIDTH(GCD_W)) in_bus ();
  egcd_out_if #(.WIDTH(GCD_W)) out_bus ();

  extended_euclid_gcd_core #(.WIDTH(GCD_W)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  bezout_tracker gcd_tracker = new();

  int burst_left;
  int ready_mode;
  int mode_left;

  // Free-running clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard limit on run time.
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  // Random sign, applied to a magnitude.
  function automatic word_t with_sign(word_t mag);
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  function automatic word_t fibonacci(int k);
    word_t f0, f1, f2;
    f0 = 0;
    f1 = 1;
    for (int i = 1; i < k; i++) begin
      f2 = f0 + f1;
      f0 = f1;
      f1 = f2;
    end
    return f1;
  endfunction

  // Random gaps between bursts of items on the operand channel.
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // Presents one operand pair and holds it until the core takes it.
  task automatic send_pair(word_t value_a, word_t value_b);
    in_bus.valid   <= 1'b1;
    in_bus.value_a <= value_a;
    in_bus.value_b <= value_b;
    do @(posedge clk_i); while (!in_bus.ready);
    gcd_tracker.note_pair(value_a, value_b);
  endtask

  // Holds the operand channel idle until every result has been returned.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (gcd_tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Draws one random operand pair from a mix of shapes.
  task automatic pick_operands(output word_t value_a, output word_t value_b);
    word_t g, m, t;
    int    k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        value_a = $urandom;
        value_b = $urandom;
      end
      3: begin
        // Shared factor, so the gcd is usually above one.
        g = $urandom_range(1, 1000);
        value_a = with_sign(g * $urandom_range(1, 2000000));
        value_b = with_sign(g * $urandom_range(1, 2000000));
      end
      4: begin
        // One magnitude a multiple of the other.
        m = $urandom_range(1, 50000);
        t = m * $urandom_range(1, 40000);
        if ($urandom_range(0, 1) == 1) begin
          value_a = with_sign(m);
          value_b = with_sign(t);
        end else begin
          value_a = with_sign(t);
          value_b = with_sign(m);
        end
      end
      5: begin
        value_a = with_sign($urandom_range(0, 255));
        value_b = with_sign($urandom_range(0, 255));
      end
      6: begin
        if ($urandom_range(0, 1) == 1) begin
          value_a = 0;
          value_b = $urandom;
        end else begin
          value_a = $urandom;
          value_b = 0;
        end
      end
      7: begin
        // Consecutive Fibonacci numbers give the longest iteration counts.
        k = $urandom_range(20, 46);
        if ($urandom_range(0, 1) == 1) begin
          value_a = with_sign(fibonacci(k));
          value_b = with_sign(fibonacci(k - 1));
        end else begin
          value_a = with_sign(fibonacci(k - 1));
          value_b = with_sign(fibonacci(k));
        end
      end
      8: begin
        m = $urandom;
        value_a = with_sign(m);
        value_b = with_sign(m);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: value_a = MAX_POS;
          1: value_a = MOST_NEG;
          2: value_a = MOST_NEG + 1;
          3: value_a = 1;
          default: value_a = -1;
        endcase
        value_b = ($urandom_range(0, 1) == 1) ? with_sign(MAX_POS) : $urandom;
      end
    endcase
  endtask

  // Operand stimulus: directed cases, then random pairs.
  initial begin
    word_t op_a, op_b;
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.value_a <= '0;
    in_bus.value_b <= '0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Zero operands, divisibility, equal magnitudes, the range extremes and Fibonacci pairs.
    send_pair(0, 0);
    send_pair(-25, 0);
    send_pair(0, -49);
    send_pair(12, 36);
    send_pair(-36, 12);
    send_pair(7, -7);
    send_pair(MAX_POS, MAX_POS);
    send_pair(MAX_POS, 1);
    send_pair(1, MAX_POS);
    send_pair(MOST_NEG, 0);
    send_pair(MOST_NEG, MAX_POS);
    send_pair(MOST_NEG, 3);
    send_pair(5, MOST_NEG);
    send_pair(MOST_NEG, MOST_NEG);
    send_pair(240, 46);
    send_pair(46, -240);
    send_pair(FIB_46, FIB_45);
    send_pair(-FIB_45, FIB_46);
    send_pair(MAX_POS, MAX_POS - 1);
    send_pair(-1, -1);
    send_pair(1, 0);
    send_pair(99991 * 3, 99991 * 5);
    send_pair(32'h5555_5555, 32'h2AAA_AAAA);

    drain_results();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        drain_results();
      end
      pick_operands(op_a, op_b);
      pace_sender();
      send_pair(op_a, op_b);
    end
    in_bus.valid <= 1'b0;

    // Let the last results come back, then watch for strays.
    while (gcd_tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (gcd_tracker.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: check every accepted item and stall on a pattern of its own.
  initial begin
    out_bus.ready <= 1'b0;
    ready_mode = 0;
    mode_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        gcd_tracker.check_result(out_bus.divisor, out_bus.coef_a, out_bus.coef_b);
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = (ready_mode == 3) ? $urandom_range(5, 40) : $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 1) == 1);
        2: out_bus.ready <= (mode_left % 4 == 0);
        default: out_bus.ready <= 1'b0;
      endcase
    end
  end

endmodule
